FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LBPM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define LBPM_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: src/lbpm_pkg.sv
package lbpm_pkg;

    localparam int COORD_W    = 15;
    localparam int TILT_W     = 11;
    localparam int RATIO_W    = 12;
    localparam int RATIO_FRAC = 8;
    localparam int SUM_W      = COORD_W + 1;
    localparam int OFF_W      = COORD_W + 2;
    localparam int SQ_W       = 2 * OFF_W;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DIST_W     = 16;
    // four-point sums carry a factor of 4, so squares carry 16
    localparam int DIST_SHIFT = 4;

    localparam int LEN_NUM    = 3;
    localparam int LEN_DEN    = 5;
    localparam int LEN_W      = COORD_W + 3;
    localparam int BIG_NUM    = 7;
    localparam int BIG_DEN    = 4;
    localparam int BIG_W      = SUM_W + 3;
    localparam int PROD_W     = RATIO_W + SUM_W;

    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 2;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam int LBPM_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TILT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd4;

    typedef struct packed {
        logic [TILT_W-1:0]  max_tilt_difference;
        logic [RATIO_W-1:0] min_pair_ratio;
        logic [RATIO_W-1:0] max_pair_ratio;
        logic [COORD_W-1:0] image_center_x;
        logic [COORD_W-1:0] image_center_y;
    } lbpm_cfg_t;

    localparam lbpm_cfg_t CFG_RESET = '{
        max_tilt_difference: 11'd160,
        min_pair_ratio:      12'd256,
        max_pair_ratio:      12'd1280,
        image_center_x:      15'd10240,
        image_center_y:      15'd8192
    };

    typedef struct packed {
        logic [3:0]         pad;
        logic [TILT_W-1:0]  right_tilt;
        logic [COORD_W-1:0] right_length;
        logic [COORD_W-1:0] right_bottom_y;
        logic [COORD_W-1:0] right_bottom_x;
        logic [COORD_W-1:0] right_top_y;
        logic [COORD_W-1:0] right_top_x;
        logic [TILT_W-1:0]  left_tilt;
        logic [COORD_W-1:0] left_length;
        logic [COORD_W-1:0] left_bottom_y;
        logic [COORD_W-1:0] left_bottom_x;
        logic [COORD_W-1:0] left_top_y;
        logic [COORD_W-1:0] left_top_x;
    } lbpm_pair_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic [DIST_W-1:0]  center_distance;
        logic [COORD_W-1:0] box_height;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_left;
    } lbpm_result_t;

    typedef struct packed {
        logic is_big_plate;
        logic pair_valid;
    } lbpm_flags_t;

    typedef struct packed {
        logic               pair_valid;
        logic               is_big_plate;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic [OFF_W-1:0]   ddx;
        logic [OFF_W-1:0]   ddy;
    } lbpm_entry_t;

endpackage

FILE: src/light_bar_pair_matcher_unit.sv
// Channel   Dir  Ports                           Content
// s_        in   s_tvalid/s_tready/s_tdata       one candidate bar pair per transfer
// m_        out  m_tvalid/m_tready/m_tdata/user  one match result per transfer
// apb       in   psel/penable/pwrite/paddr/...   five config registers at 4*i
//
// One transfer per cycle in each direction when neither side stalls.
// The path from s_ transfer to m_tvalid runs through 2 classify stages, the
// queue, square and sum stages, then 16 square-root stages (one bit each).
// aresetn (sync, active low) empties all stages and the queue and loads the
// register reset values.
// m_tready low while m_tvalid is high freezes the result pipeline; the queue
// absorbs up to QUEUE_DEPTH entries before s_tready drops.

module light_bar_pair_matcher_unit
    import lbpm_pkg::*;
#(
    parameter int QUEUE_DEPTH = LBPM_QUEUE_DEPTH
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_top_x, left_top_y, left_bottom_x, left_bottom_y, left_length,
    // left_tilt, right_top_x, right_top_y, right_bottom_x, right_bottom_y,
    // right_length, right_tilt, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // box_left, box_top, box_width, box_height, center_distance, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // pair_valid, is_big_plate
    output logic [M_TUSER_W-1:0]  m_tuser
);

    lbpm_cfg_t             cfg_reg;
    logic                  cfg_wr;
    logic [CFG_IDX_W-1:0]  cfg_idx;

    logic                  fq_valid, fq_ready;
    lbpm_entry_t           fq_entry;
    logic                  qb_valid, qb_ready;
    lbpm_entry_t           qb_entry;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAX_TILT:  cfg_reg.max_tilt_difference <= pwdata[TILT_W-1:0];
                REG_MIN_RATIO: cfg_reg.min_pair_ratio      <= pwdata[RATIO_W-1:0];
                REG_MAX_RATIO: cfg_reg.max_pair_ratio      <= pwdata[RATIO_W-1:0];
                REG_CENTER_X:  cfg_reg.image_center_x      <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:  cfg_reg.image_center_y      <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAX_TILT:  prdata = CFG_DATA_W'(cfg_reg.max_tilt_difference);
            REG_MIN_RATIO: prdata = CFG_DATA_W'(cfg_reg.min_pair_ratio);
            REG_MAX_RATIO: prdata = CFG_DATA_W'(cfg_reg.max_pair_ratio);
            REG_CENTER_X:  prdata = CFG_DATA_W'(cfg_reg.image_center_x);
            REG_CENTER_Y:  prdata = CFG_DATA_W'(cfg_reg.image_center_y);
            default:       prdata = '0;
        endcase
    end

    lbpm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_entry  (fq_entry)
    );

    lbpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    lbpm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_entry  (qb_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: src/lbpm_front.sv
`include "assert_macros.svh"

module lbpm_front
    import lbpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lbpm_cfg_t            cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lbpm_entry_t          q_entry
);

    typedef struct packed {
        logic               tilt_ok;
        logic [COORD_W-1:0] lmin;
        logic [COORD_W-1:0] lmax;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   dy2;
        logic               dx_pos;
        logic [SUM_W-1:0]   dx2;
        logic [COORD_W-1:0] minx;
        logic [COORD_W-1:0] maxx;
        logic [COORD_W-1:0] miny;
        logic [COORD_W-1:0] maxy;
        logic [OFF_W-1:0]   sx4;
        logic [OFF_W-1:0]   sy4;
    } lbpm_stage1_t;

    function automatic logic [COORD_W-1:0] min2(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [COORD_W-1:0] max2(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    lbpm_pair_t   pair;
    lbpm_stage1_t s1_next, s1_reg;
    lbpm_entry_t  s2_next, s2_reg;
    logic         s1_valid_reg, s2_valid_reg;
    logic         adv;

    logic [TILT_W-1:0]  tdiff;
    logic [SUM_W-1:0]   lcx2, lcy2, rcx2, rcy2;
    logic               len_ok, dy_ok, band_ok, ok, big;
    logic [PROD_W-1:0]  lhs, lo_bound, hi_bound;
    logic [COORD_W-1:0] bw, bh;
    logic [OFF_W-1:0]   icx4, icy4;

    assign pair     = lbpm_pair_t'(s_tdata);
    assign adv      = !s2_valid_reg || q_ready;
    assign s_tready = adv;
    assign q_valid  = s2_valid_reg;
    assign q_entry  = s2_reg;

    // stage 1: tilt test, length extremes, centers, offsets, extremes
    always_comb begin
        tdiff = (pair.left_tilt > pair.right_tilt) ? pair.left_tilt - pair.right_tilt
                                                   : pair.right_tilt - pair.left_tilt;
        lcx2 = SUM_W'(pair.left_top_x) + SUM_W'(pair.left_bottom_x);
        lcy2 = SUM_W'(pair.left_top_y) + SUM_W'(pair.left_bottom_y);
        rcx2 = SUM_W'(pair.right_top_x) + SUM_W'(pair.right_bottom_x);
        rcy2 = SUM_W'(pair.right_top_y) + SUM_W'(pair.right_bottom_y);

        s1_next.tilt_ok = (tdiff <= cfg.max_tilt_difference);
        s1_next.lmin    = min2(pair.left_length, pair.right_length);
        s1_next.lmax    = max2(pair.left_length, pair.right_length);
        s1_next.sum     = SUM_W'(pair.left_length) + SUM_W'(pair.right_length);
        s1_next.dy2     = (lcy2 > rcy2) ? lcy2 - rcy2 : rcy2 - lcy2;
        s1_next.dx_pos  = (rcx2 > lcx2);
        s1_next.dx2     = rcx2 - lcx2;
        s1_next.minx    = min2(min2(pair.left_bottom_x, pair.right_bottom_x),
                               min2(pair.right_top_x, pair.left_top_x));
        s1_next.maxx    = max2(max2(pair.left_bottom_x, pair.right_bottom_x),
                               max2(pair.right_top_x, pair.left_top_x));
        s1_next.miny    = min2(min2(pair.left_bottom_y, pair.right_bottom_y),
                               min2(pair.right_top_y, pair.left_top_y));
        s1_next.maxy    = max2(max2(pair.left_bottom_y, pair.right_bottom_y),
                               max2(pair.right_top_y, pair.left_top_y));
        s1_next.sx4     = OFF_W'(pair.left_bottom_x) + OFF_W'(pair.right_bottom_x)
                        + OFF_W'(pair.right_top_x) + OFF_W'(pair.left_top_x);
        s1_next.sy4     = OFF_W'(pair.left_bottom_y) + OFF_W'(pair.right_bottom_y)
                        + OFF_W'(pair.right_top_y) + OFF_W'(pair.left_top_y);
    end

    // stage 2: ratio tests, box, big plate flag, offsets to image center
    always_comb begin
        len_ok   = (LEN_W'(s1_reg.lmin) * LEN_W'(LEN_DEN))
                >= (LEN_W'(s1_reg.lmax) * LEN_W'(LEN_NUM));
        dy_ok    = ({s1_reg.dy2, 1'b0} <= {1'b0, s1_reg.sum});
        lhs      = PROD_W'({s1_reg.dx2, {RATIO_FRAC{1'b0}}});
        lo_bound = PROD_W'(cfg.min_pair_ratio) * PROD_W'(s1_reg.sum);
        hi_bound = PROD_W'(cfg.max_pair_ratio) * PROD_W'(s1_reg.sum);
        band_ok  = s1_reg.dx_pos && (lhs >= lo_bound) && (lhs <= hi_bound);
        ok       = s1_reg.tilt_ok && len_ok && dy_ok && band_ok;

        bw   = s1_reg.maxx - s1_reg.minx;
        bh   = s1_reg.maxy - s1_reg.miny;
        big  = (BIG_W'(bw) * BIG_W'(BIG_DEN)) > (BIG_W'(s1_reg.sum) * BIG_W'(BIG_NUM));
        icx4 = {cfg.image_center_x, 2'b00};
        icy4 = {cfg.image_center_y, 2'b00};

        s2_next = '0;
        if (ok) begin
            s2_next.pair_valid   = 1'b1;
            s2_next.is_big_plate = big;
            s2_next.box_left     = s1_reg.minx;
            s2_next.box_top      = s1_reg.miny;
            s2_next.box_width    = bw;
            s2_next.box_height   = bh;
            s2_next.ddx = (s1_reg.sx4 > icx4) ? s1_reg.sx4 - icx4 : icx4 - s1_reg.sx4;
            s2_next.ddy = (s1_reg.sy4 > icy4) ? s1_reg.sy4 - icy4 : icy4 - s1_reg.sy4;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    `LBPM_ASSERT(a_front_hold, aclk, aresetn, s2_valid_reg && !q_ready |=> s2_valid_reg && $stable(s2_reg), "front entry changed while stalled")

endmodule

FILE: src/lbpm_queue.sv
`include "assert_macros.svh"

module lbpm_queue
    import lbpm_pkg::*;
#(
    parameter int DEPTH = LBPM_QUEUE_DEPTH
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  lbpm_entry_t in_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output lbpm_entry_t out_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbpm_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    `LBPM_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `LBPM_ASSERT(a_empty_ptrs, aclk, aresetn, count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")

endmodule

FILE: src/lbpm_back.sv
`include "assert_macros.svh"

module lbpm_back
    import lbpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  lbpm_entry_t          q_entry,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int REM_W = ROOT_W + 1;
    localparam int SH_W  = REM_W + 2;

    typedef struct packed {
        logic               pair_valid;
        logic               is_big_plate;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } lbpm_meta_t;

    logic              adv;
    logic              sq_valid_reg, rad_valid_reg;
    lbpm_meta_t        q_meta, sq_meta_reg, rad_meta_reg;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg;
    logic [SQ_W:0]     sq_sum;
    logic [RAD_W-1:0]  rad_reg;

    logic [REM_W-1:0]  in_rem   [ROOT_W];
    logic [ROOT_W-1:0] in_root  [ROOT_W];
    logic [RAD_W-1:0]  in_rad   [ROOT_W];
    lbpm_meta_t        in_meta  [ROOT_W];
    logic [ROOT_W-1:0] in_valid;
    logic [SH_W-1:0]   rem_sh   [ROOT_W];
    logic [SH_W-1:0]   trial    [ROOT_W];
    logic [ROOT_W-1:0] ge;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  rt_rad_reg [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    lbpm_meta_t        meta_reg [ROOT_W];
    logic [ROOT_W-1:0] rt_valid_reg;

    lbpm_result_t      result;
    lbpm_flags_t       flags;

    assign adv      = !rt_valid_reg[ROOT_W-1] || m_tready;
    assign q_ready  = adv;
    assign m_tvalid = rt_valid_reg[ROOT_W-1];

    assign q_meta = '{
        pair_valid:   q_entry.pair_valid,
        is_big_plate: q_entry.is_big_plate,
        box_left:     q_entry.box_left,
        box_top:      q_entry.box_top,
        box_width:    q_entry.box_width,
        box_height:   q_entry.box_height
    };

    assign sq_sum = (SQ_W + 1)'(sq_x_reg) + (SQ_W + 1)'(sq_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            rad_valid_reg <= 1'b0;
        end else if (adv) begin
            sq_valid_reg  <= q_valid;
            rad_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_meta_reg  <= q_meta;
            sq_x_reg     <= SQ_W'(q_entry.ddx) * SQ_W'(q_entry.ddx);
            sq_y_reg     <= SQ_W'(q_entry.ddy) * SQ_W'(q_entry.ddy);
            rad_meta_reg <= sq_meta_reg;
            rad_reg      <= RAD_W'(sq_sum >> DIST_SHIFT);
        end
    end

    // square root, one result bit per stage
    assign in_rem[0]   = '0;
    assign in_root[0]  = '0;
    assign in_rad[0]   = rad_reg;
    assign in_meta[0]  = rad_meta_reg;
    assign in_valid[0] = rad_valid_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        if (k > 0) begin : g_link
            assign in_rem[k]   = rem_reg[k-1];
            assign in_root[k]  = root_reg[k-1];
            assign in_rad[k]   = rt_rad_reg[k-1];
            assign in_meta[k]  = meta_reg[k-1];
            assign in_valid[k] = rt_valid_reg[k-1];
        end

        assign rem_sh[k] = {in_rem[k], in_rad[k][RAD_W-1 -: 2]};
        assign trial[k]  = SH_W'({in_root[k], 2'b01});
        assign ge[k]     = (rem_sh[k] >= trial[k]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                rt_valid_reg[k] <= in_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                root_reg[k] <= {in_root[k][ROOT_W-2:0], ge[k]};
                meta_reg[k] <= in_meta[k];
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k]    <= REM_W'(ge[k] ? rem_sh[k] - trial[k] : rem_sh[k]);
                    rt_rad_reg[k] <= {in_rad[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    always_comb begin
        result                 = '0;
        result.box_left        = meta_reg[ROOT_W-1].box_left;
        result.box_top         = meta_reg[ROOT_W-1].box_top;
        result.box_width       = meta_reg[ROOT_W-1].box_width;
        result.box_height      = meta_reg[ROOT_W-1].box_height;
        result.center_distance = DIST_W'(root_reg[ROOT_W-1]);
        flags.pair_valid       = meta_reg[ROOT_W-1].pair_valid;
        flags.is_big_plate     = meta_reg[ROOT_W-1].is_big_plate;
    end

    assign m_tdata = result;
    assign m_tuser = flags;

    `LBPM_ASSERT(a_reject_zero, aclk, aresetn, m_tvalid && !flags.pair_valid |-> result == '0, "rejected pair carries data")
    `LBPM_ASSERT_NEVER(a_big_needs_valid, aclk, aresetn, m_tvalid && flags.is_big_plate && !flags.pair_valid, "big plate flag on rejected pair")

endmodule

FILE: bench/testbench.sv
module testbench;
    import lbpm_pkg::*;

    localparam int PIPE_LATENCY = 20;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int TILT_MAX     = (1 << TILT_W) - 1;
    localparam int TILT_LIMIT   = 1440;
    localparam int RATIO_MAX    = (1 << RATIO_W) - 1;
    localparam int PHASE_ITEMS  = 135;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        lbpm_flags_t  flags;
        lbpm_result_t res;
    } match_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    lbpm_cfg_t cfg_shadow;
    match_t    pending_matches[$];
    int        mismatch_count = 0;
    int        tx_gap_pct     = 0;
    int        rx_stall_pct   = 0;

    light_bar_pair_matcher_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit [63:0] lesser(bit [63:0] a, bit [63:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic bit [63:0] greater(bit [63:0] a, bit [63:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic bit [63:0] abs_diff(bit [63:0] a, bit [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit [63:0] root_floor(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] trial;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    function automatic match_t predict_match(lbpm_pair_t p);
        match_t    m;
        bit [63:0] ltx, lty, lbx, lby, llen, ltl, rtx, rty, rbx, rby, rlen, rtl;
        bit [63:0] lsum, lcx2, lcy2, rcx2, rcy2, dx2;
        bit [63:0] minx, maxx, miny, maxy, bw, bh, ddx, ddy, span;
        bit        ok;
        m = '0;
        ok = 1'b1;
        ltx = 64'(p.left_top_x);     lty = 64'(p.left_top_y);
        lbx = 64'(p.left_bottom_x);  lby = 64'(p.left_bottom_y);
        llen = 64'(p.left_length);   ltl = 64'(p.left_tilt);
        rtx = 64'(p.right_top_x);    rty = 64'(p.right_top_y);
        rbx = 64'(p.right_bottom_x); rby = 64'(p.right_bottom_y);
        rlen = 64'(p.right_length);  rtl = 64'(p.right_tilt);

        if (abs_diff(ltl, rtl) > 64'(cfg_shadow.max_tilt_difference)) ok = 1'b0;
        if (lesser(llen, rlen) * 5 < greater(llen, rlen) * 3) ok = 1'b0;
        lsum = llen + rlen;
        lcx2 = ltx + lbx;
        lcy2 = lty + lby;
        rcx2 = rtx + rbx;
        rcy2 = rty + rby;
        if (abs_diff(lcy2, rcy2) * 2 > lsum) ok = 1'b0;
        if (rcx2 <= lcx2) begin
            ok = 1'b0;
        end else begin
            dx2 = (rcx2 - lcx2) << RATIO_FRAC;
            if (dx2 < 64'(cfg_shadow.min_pair_ratio) * lsum ||
                dx2 > 64'(cfg_shadow.max_pair_ratio) * lsum) ok = 1'b0;
        end
        if (!ok) return m;

        minx = lesser(lesser(lbx, rbx), lesser(rtx, ltx));
        maxx = greater(greater(lbx, rbx), greater(rtx, ltx));
        miny = lesser(lesser(lby, rby), lesser(rty, lty));
        maxy = greater(greater(lby, rby), greater(rty, lty));
        bw = maxx - minx;
        bh = maxy - miny;
        ddx = abs_diff(lbx + rbx + rtx + ltx, 64'(cfg_shadow.image_center_x) * 4);
        ddy = abs_diff(lby + rby + rty + lty, 64'(cfg_shadow.image_center_y) * 4);
        span = root_floor((ddx * ddx + ddy * ddy) >> DIST_SHIFT);
        if (span > 64'hFFFF) span = 64'hFFFF;

        m.flags.pair_valid   = 1'b1;
        m.flags.is_big_plate = (bw * 4 > lsum * 7);
        m.res.box_left        = minx[COORD_W-1:0];
        m.res.box_top         = miny[COORD_W-1:0];
        m.res.box_width       = bw[COORD_W-1:0];
        m.res.box_height      = bh[COORD_W-1:0];
        m.res.center_distance = span[DIST_W-1:0];
        return m;
    endfunction

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    // vertical bars given by center, length and tilt
    function automatic lbpm_pair_t bars(int lx, int ly, int llen, int ltilt,
                                        int rx, int ry, int rlen, int rtilt);
        lbpm_pair_t p;
        p = '0;
        p.left_top_x     = COORD_W'(lx);
        p.left_bottom_x  = COORD_W'(lx);
        p.left_top_y     = COORD_W'(ly - llen / 2);
        p.left_bottom_y  = COORD_W'(ly + llen / 2);
        p.left_length    = COORD_W'(llen);
        p.left_tilt      = TILT_W'(ltilt);
        p.right_top_x    = COORD_W'(rx);
        p.right_bottom_x = COORD_W'(rx);
        p.right_top_y    = COORD_W'(ry - rlen / 2);
        p.right_bottom_y = COORD_W'(ry + rlen / 2);
        p.right_length   = COORD_W'(rlen);
        p.right_tilt     = TILT_W'(rtilt);
        return p;
    endfunction

    // mostly plausible pairs aimed at the current limits, some raw noise
    function automatic lbpm_pair_t random_pair();
        lbpm_pair_t   p;
        bit [191:0]   raw;
        int len_l, len_r, tmp, mean, lo, hi, dx, dy, lcx, lcy, skew_l, skew_r, tdelta;
        if ($urandom_range(0, 99) < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            p = raw[S_TDATA_W-1:0];
            p.pad = '0;
            return p;
        end
        len_l = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COORD_MAX)
                                            : $urandom_range(8, 2400);
        len_r = len_l * $urandom_range(55, 100) / 100;
        if ($urandom_range(0, 1) != 0) begin
            tmp = len_l;
            len_l = len_r;
            len_r = tmp;
        end
        mean = (len_l + len_r) / 2;
        lo = clip(int'(cfg_shadow.min_pair_ratio) - 24, RATIO_MAX);
        hi = int'(cfg_shadow.max_pair_ratio) + 24;
        if (hi < lo) hi = lo + 64;
        dx = mean * $urandom_range(lo, hi) / 256;
        dy = $urandom_range(0, mean / 2 + 4);
        if ($urandom_range(0, 1) != 0) dy = -dy;
        lcx = $urandom_range(0, clip(COORD_MAX - dx, COORD_MAX));
        lcy = $urandom_range(0, COORD_MAX);
        skew_l = $urandom_range(0, len_l / 4);
        skew_r = $urandom_range(0, len_r / 4);
        if ($urandom_range(0, 1) != 0) skew_l = -skew_l;
        if ($urandom_range(0, 1) != 0) skew_r = -skew_r;
        tdelta = $urandom_range(0, int'(cfg_shadow.max_tilt_difference) + 16);
        if ($urandom_range(0, 1) != 0) tdelta = -tdelta;

        p = '0;
        p.left_top_x     = COORD_W'(clip(lcx + skew_l, COORD_MAX));
        p.left_bottom_x  = COORD_W'(clip(lcx - skew_l, COORD_MAX));
        p.left_top_y     = COORD_W'(clip(lcy - len_l / 2, COORD_MAX));
        p.left_bottom_y  = COORD_W'(clip(lcy + len_l / 2, COORD_MAX));
        p.left_length    = COORD_W'(len_l);
        p.left_tilt      = TILT_W'($urandom_range(0, TILT_LIMIT));
        p.right_top_x    = COORD_W'(clip(lcx + dx + skew_r, COORD_MAX));
        p.right_bottom_x = COORD_W'(clip(lcx + dx - skew_r, COORD_MAX));
        p.right_top_y    = COORD_W'(clip(lcy + dy - len_r / 2, COORD_MAX));
        p.right_bottom_y = COORD_W'(clip(lcy + dy + len_r / 2, COORD_MAX));
        p.right_length   = COORD_W'(len_r);
        p.right_tilt     = TILT_W'(clip(int'(p.left_tilt) + tdelta, TILT_MAX));
        return p;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        match_t got;
        match_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.flags = m_tuser;
            got.res   = m_tdata;
            if (pending_matches.size() == 0) begin
                flag_error("result transfer with no pending pair");
            end else begin
                want = pending_matches.pop_front();
                if (got.flags.pair_valid   !== want.flags.pair_valid   ||
                    got.flags.is_big_plate !== want.flags.is_big_plate ||
                    got.res.box_left       !== want.res.box_left       ||
                    got.res.box_top        !== want.res.box_top        ||
                    got.res.box_width      !== want.res.box_width      ||
                    got.res.box_height     !== want.res.box_height     ||
                    got.res.center_distance !== want.res.center_distance)
                    flag_error($sformatf(
                        "match mismatch: exp v=%0d b=%0d box=%0d,%0d,%0d,%0d d=%0d | got v=%0d b=%0d box=%0d,%0d,%0d,%0d d=%0d",
                        want.flags.pair_valid, want.flags.is_big_plate, want.res.box_left,
                        want.res.box_top, want.res.box_width, want.res.box_height,
                        want.res.center_distance, got.flags.pair_valid,
                        got.flags.is_big_plate, got.res.box_left, got.res.box_top,
                        got.res.box_width, got.res.box_height, got.res.center_distance));
            end
        end
    end

    task automatic send_pair(input lbpm_pair_t p);
        int gap;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        pending_matches.insert(pending_matches.size(), predict_match(p));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 5) @(posedge aclk);
    endtask

    // upper bits beyond the register width get junk half the time
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        int unsigned junk;
        int          w;
        junk = ($urandom_range(0, 1) != 0) ? $urandom : 0;
        w = CFG_DATA_W;
        case (idx)
            REG_MAX_TILT: begin
                w = TILT_W;
                cfg_shadow.max_tilt_difference = TILT_W'(value);
            end
            REG_MIN_RATIO: begin
                w = RATIO_W;
                cfg_shadow.min_pair_ratio = RATIO_W'(value);
            end
            REG_MAX_RATIO: begin
                w = RATIO_W;
                cfg_shadow.max_pair_ratio = RATIO_W'(value);
            end
            REG_CENTER_X: begin
                w = COORD_W;
                cfg_shadow.image_center_x = COORD_W'(value);
            end
            REG_CENTER_Y: begin
                w = COORD_W;
                cfg_shadow.image_center_y = COORD_W'(value);
            end
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (w < CFG_DATA_W) ? (value | (junk << w)) : value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_limits(input int tilt, input int lo, input int hi,
                                input int cx, input int cy);
        write_register(REG_MAX_TILT, tilt);
        write_register(REG_MIN_RATIO, lo);
        write_register(REG_MAX_RATIO, hi);
        write_register(REG_CENTER_X, cx);
        write_register(REG_CENTER_Y, cy);
    endtask

    task automatic send_random_pairs(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    // runs at reset limits: tilt 10 deg, ratio band 1.0 to 5.0
    task automatic test_directed_pairs();
        lbpm_pair_t p;
        tx_gap_pct = 13;
        rx_stall_pct = 55;
        p = '0;
        send_pair(p);
        p = '1;
        p.pad = '0;
        send_pair(p);
        send_pair(bars(1000, 1000, 160, 100, 1320, 1000, 160, 100));
        // tilt difference at and past the limit
        send_pair(bars(1000, 1000, 160, 0, 1320, 1000, 160, 160));
        send_pair(bars(1000, 1000, 160, 0, 1320, 1000, 160, 161));
        // tilts beyond 90 deg
        send_pair(bars(1000, 1000, 160, TILT_MAX, 1320, 1000, 160, 1900));
        // length ratio exactly 0.6, then just below
        send_pair(bars(2000, 2000, 300, 50, 3000, 2000, 500, 50));
        send_pair(bars(2000, 2000, 298, 50, 3000, 2000, 500, 50));
        // vertical offset at half the mean length, then past
        send_pair(bars(1000, 1000, 160, 0, 1320, 1080, 160, 0));
        send_pair(bars(1000, 1000, 160, 0, 1320, 1081, 160, 0));
        // spacing at both band edges and just outside
        send_pair(bars(1000, 1000, 160, 0, 1160, 1000, 160, 0));
        send_pair(bars(1000, 1000, 160, 0, 1159, 1000, 160, 0));
        send_pair(bars(1000, 1000, 160, 0, 1800, 1000, 160, 0));
        send_pair(bars(1000, 1000, 160, 0, 1801, 1000, 160, 0));
        // big plate threshold
        send_pair(bars(1000, 1000, 160, 0, 1560, 1000, 160, 0));
        send_pair(bars(1000, 1000, 160, 0, 1561, 1000, 160, 0));
        // right bar left of left bar
        send_pair(bars(1320, 1000, 160, 0, 1000, 1000, 160, 0));
        // both lengths zero
        send_pair(bars(1000, 1000, 0, 0, 1200, 1000, 0, 0));
        // plate centered on the image center
        send_pair(bars(10240 - 160, 8192, 160, 0, 10240 + 160, 8192, 160, 0));
        send_pair(bars(COORD_MAX - 320, COORD_MAX - 80, 160, 0,
                       COORD_MAX, COORD_MAX - 80, 160, 0));
        send_pair(bars(0, 80, 160, 0, 320, 80, 160, 0));
    endtask

    task automatic test_register_extremes();
        wait_drained();
        write_limits(0, 0, 0, 0, 0);
        write_register(REG_UNUSED, $urandom);
        send_random_pairs(30);
        wait_drained();
        write_limits(TILT_LIMIT, RATIO_MAX, RATIO_MAX, COORD_MAX, COORD_MAX);
        send_random_pairs(30);
        wait_drained();
        write_limits(TILT_LIMIT, 0, RATIO_MAX, 0, COORD_MAX);
        send_random_pairs(30);
        wait_drained();
        write_limits(0, 256, 256, COORD_MAX, 0);
        send_random_pairs(30);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int lo;
        tx_gap_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (2) begin
            wait_drained();
            if ($urandom_range(0, 4) == 0) begin
                write_limits($urandom_range(0, TILT_LIMIT), $urandom_range(0, RATIO_MAX),
                             $urandom_range(0, RATIO_MAX), $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX));
            end else begin
                lo = $urandom_range(0, 768);
                write_limits($urandom_range(0, TILT_LIMIT), lo,
                             clip(lo + $urandom_range(256, 2048), RATIO_MAX),
                             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
            send_random_pairs(PHASE_ITEMS);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_shadow = CFG_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed_pairs();
        test_register_extremes();
        test_random_traffic(13, 55);
        test_random_traffic(55, 13);
        test_random_traffic(0, 0);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
